// File: hw/rtl/rlr_pkg.sv
// Shared types, character codes and phase codes for the real literal recogniser.
package rlr_pkg;

    // Width of the internal digit counters
    localparam int COUNT_BITS = 8;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;

    // Word index codes
    localparam logic [1:0] WI_INT  = 2'd0;
    localparam logic [1:0] WI_SEP  = 2'd1;
    localparam logic [1:0] WI_FRAC = 2'd2;

    // Scan phase codes
    localparam logic [2:0] PH_INT   = 3'd0;
    localparam logic [2:0] PH_FRAC  = 3'd1;
    localparam logic [2:0] PH_ESYM  = 3'd2;
    localparam logic [2:0] PH_ESIGN = 3'd3;
    localparam logic [2:0] PH_EXP   = 3'd4;

    // Verdict codes
    localparam logic [1:0] VERDICT_REJECT = 2'd0;
    localparam logic [1:0] VERDICT_ONE    = 2'd1;
    localparam logic [1:0] VERDICT_THREE  = 2'd2;

    // Input word: one character of the candidate
    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] word_index;
        logic       word_last;
        logic       attempt_last;
    } t_in_word;

    // Output word: verdict and digit counts
    typedef struct packed {
        logic [1:0] verdict;
        logic [7:0] int_digits;
        logic [7:0] frac_digits;
        logic [7:0] exp_digits;
        logic       exp_present;
        logic       exp_negative;
        logic       point_present;
    } t_out_word;

endpackage

// File: hw/rtl/real_literal_recognizer_top.sv
// Top level of the real literal recogniser: input register, scanner, result register.
// Recognises decimal real literals of the form digits [ '.' digits ] [ e|E [+|-] digits ]
// from a stream of characters, one word per cycle unless the input is stalled. Each
// character is captured in an input register and, when it advances, runs through the
// scanner logic into the result register; a new word is accepted every cycle unless
// stalled. A character that ends the candidate produces one result word; other
// characters produce none and never wait on the output side. The output register
// decouples the two channels, so input is stalled only while a finishing character waits
// behind an unread result.
module real_literal_recognizer_top import rlr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      s_out_free;
    logic      s_advance;
    logic      s_emit;
    t_out_word s_result;

    // Handshake: a character that ends a candidate needs room in the result register
    assign s_out_free = !r_out_valid || !i_out_stall;
    assign s_advance  = r_in_valid && (!r_in_word.attempt_last || s_out_free);
    assign o_in_stall = r_in_valid && !s_advance;

    rlr_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(s_advance),
        .i_word   (r_in_word),
        .o_emit   (s_emit),
        .o_result (s_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_out_word <= s_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: hw/rtl/rlr_scan.sv
// Scanner state and per-character next-state and verdict logic.
module rlr_scan import rlr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_word  i_word,
    output logic      o_emit,
    output t_out_word o_result
);

    typedef struct packed {
        logic [2:0]            phase;
        logic                  e_seen;
        logic                  coeff_first_zero;
        logic [COUNT_BITS-1:0] int_count;
        logic [COUNT_BITS-1:0] frac_count;
        logic [COUNT_BITS-1:0] exp_count;
        logic                  exp_first_zero;
        logic                  minus_sign;
        logic                  rejected;
        logic                  early_one_word;
        logic                  separator_ok;
        logic                  sep_started;
        logic                  frac_started;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        phase: PH_INT, e_seen: 1'b0, coeff_first_zero: 1'b0,
        int_count: '0, frac_count: '0, exp_count: '0,
        exp_first_zero: 1'b0, minus_sign: 1'b0, rejected: 1'b0,
        early_one_word: 1'b0, separator_ok: 1'b0,
        sep_started: 1'b0, frac_started: 1'b0
    };

    t_scan_state r_state;
    t_scan_state n_state;
    t_scan_state s_upd;
    logic        s_ok;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    // Clamp a count to the eight-bit output range
    function automatic logic [7:0] out8(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS+7:0] w;
        w = {8'd0, v};
        out8 = (w > (COUNT_BITS+8)'(255)) ? 8'hFF : w[7:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c inside {[CH_0:CH_9]});
    endfunction

    function automatic logic is_e(input logic [7:0] c);
        is_e = (c == CH_LO_E) || (c == CH_UP_E);
    endfunction

    // One step of the literal grammar
    function automatic t_scan_state feed(input t_scan_state s, input logic [7:0] c);
        t_scan_state t;
        t = s;
        case (s.phase)
            PH_INT: begin
                if (is_digit(c)) begin
                    if (s.int_count == '0) t.coeff_first_zero = (c == CH_0);
                    t.int_count = sat_inc(s.int_count);
                end else if (is_e(c) && (s.int_count != '0)) begin
                    t.e_seen = 1'b1;
                    t.phase  = PH_ESYM;
                end else begin
                    t.rejected = 1'b1;
                end
            end
            PH_FRAC: begin
                if (is_digit(c)) begin
                    t.frac_count = sat_inc(s.frac_count);
                end else if (is_e(c)) begin
                    t.e_seen = 1'b1;
                    t.phase  = PH_ESYM;
                end else begin
                    t.rejected = 1'b1;
                end
            end
            PH_ESYM, PH_ESIGN, PH_EXP: begin
                if (is_digit(c)) begin
                    if (s.exp_count == '0) t.exp_first_zero = (c == CH_0);
                    t.exp_count = sat_inc(s.exp_count);
                    t.phase     = PH_EXP;
                end else if ((s.phase == PH_ESYM) &&
                             ((c == CH_PLUS) || (c == CH_MINUS))) begin
                    t.minus_sign = (c == CH_MINUS);
                    t.phase      = PH_ESIGN;
                end else begin
                    t.rejected = 1'b1;
                end
            end
            default: begin
                t.rejected = 1'b1;
            end
        endcase
        return t;
    endfunction

    // Update the scanner with the current character
    always_comb begin
        s_upd = r_state;
        if (!r_state.rejected) begin
            case (i_word.word_index)
                WI_INT: begin
                    if (r_state.phase == PH_FRAC) s_upd.rejected = 1'b1;
                    else                          s_upd = feed(r_state, i_word.ch);
                end
                WI_SEP: begin
                    if (!r_state.sep_started) begin
                        s_upd.sep_started  = 1'b1;
                        s_upd.separator_ok = (i_word.ch == CH_POINT) && i_word.word_last;
                    end else begin
                        s_upd.separator_ok = 1'b0;
                    end
                end
                WI_FRAC: begin
                    if (!r_state.early_one_word) begin
                        if (r_state.frac_started) begin
                            s_upd = feed(r_state, i_word.ch);
                        end else if ((r_state.phase == PH_INT) && r_state.separator_ok) begin
                            if (is_digit(i_word.ch) || is_e(i_word.ch)) begin
                                s_upd              = r_state;
                                s_upd.frac_started = 1'b1;
                                s_upd.phase        = PH_FRAC;
                                s_upd              = feed(s_upd, i_word.ch);
                            end else begin
                                s_upd.early_one_word = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    s_upd = r_state;
                end
            endcase
        end
    end

    // Final checks and result fields
    always_comb begin
        s_ok = !s_upd.rejected;
        if (s_upd.e_seen && (s_upd.exp_count == '0)) s_ok = 1'b0;
        if ((s_upd.int_count > COUNT_BITS'(1)) && s_upd.coeff_first_zero) s_ok = 1'b0;
        if ((s_upd.exp_count > COUNT_BITS'(1)) && s_upd.exp_first_zero) s_ok = 1'b0;

        o_result = '0;
        if (s_ok) begin
            o_result.verdict       = s_upd.frac_started ? VERDICT_THREE : VERDICT_ONE;
            o_result.int_digits    = out8(s_upd.int_count);
            o_result.frac_digits   = s_upd.frac_started ? out8(s_upd.frac_count) : 8'd0;
            o_result.exp_digits    = out8(s_upd.exp_count);
            o_result.exp_present   = s_upd.e_seen;
            o_result.exp_negative  = s_upd.e_seen && s_upd.minus_sign;
            o_result.point_present = s_upd.frac_started;
        end
    end

    assign o_emit  = i_advance && i_word.attempt_last;
    // Back to the start after the candidate ends
    assign n_state = i_word.attempt_last ? SCAN_RESET : s_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_RESET;
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

endmodule

// File: bench/tb.sv
// Self-checking bench for the real literal recogniser: random and directed words, scoreboard.
`timescale 1ns / 1ps

module tb import rlr_pkg::*; ();

    // Word index with no meaning to the scanner
    localparam logic [1:0] WI_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TARGET_WORDS = 1050;

    typedef struct {
        t_in_word w;
        int       gap;
        bit       drain;
    } t_pending;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    t_pending   pend_q[$];
    t_out_word  verdicts_due[$];
    logic [7:0] word_buf[$];
    int         errors = 0;
    int         cycles = 0;
    int         out_wait = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;
    bit         next_drain = 1'b0;

    // Scanner state mirrored by the predictor
    logic [2:0]  ph;
    bit          e_seen, coeff_zero, exp_zero, minus, rej, early, sep_ok;
    bit          sep_started, frac_started;
    int unsigned n_int, n_frac, n_exp;

    real_literal_recognizer_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    task automatic clear_scan();
        ph = PH_INT;
        {e_seen, coeff_zero, exp_zero, minus, rej, early, sep_ok} = '0;
        {sep_started, frac_started} = '0;
        n_int = 0;
        n_frac = 0;
        n_exp = 0;
    endtask

    function automatic int unsigned bump(input int unsigned v);
        return (v >= CNT_MAX) ? int'(CNT_MAX) : v + 1;
    endfunction

    function automatic logic [7:0] clamp8(input int unsigned v);
        return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_e(input logic [7:0] c);
        return c == CH_LO_E || c == CH_UP_E;
    endfunction

    task automatic take_exp_digit(input logic [7:0] c);
        if (n_exp == 0) exp_zero = (c == CH_0);
        n_exp = bump(n_exp);
        ph = PH_EXP;
    endtask

    // One character through the literal grammar
    task automatic scan_char(input logic [7:0] c);
        case (ph)
            PH_INT: begin
                if (is_digit(c)) begin
                    if (n_int == 0) coeff_zero = (c == CH_0);
                    n_int = bump(n_int);
                end else if (is_e(c) && n_int != 0) begin
                    e_seen = 1'b1;
                    ph = PH_ESYM;
                end else begin
                    rej = 1'b1;
                end
            end
            PH_FRAC: begin
                if (is_digit(c)) begin
                    n_frac = bump(n_frac);
                end else if (is_e(c)) begin
                    e_seen = 1'b1;
                    ph = PH_ESYM;
                end else begin
                    rej = 1'b1;
                end
            end
            PH_ESYM: begin
                if (is_digit(c)) begin
                    take_exp_digit(c);
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    minus = (c == CH_MINUS);
                    ph = PH_ESIGN;
                end else begin
                    rej = 1'b1;
                end
            end
            PH_ESIGN, PH_EXP: begin
                if (is_digit(c)) take_exp_digit(c);
                else rej = 1'b1;
            end
            default: rej = 1'b1;
        endcase
    endtask

    // Update the mirror for an accepted input word; queue a verdict on attempt end
    task automatic predict_verdict(input t_in_word w);
        t_out_word r;
        bit        ok;
        if (!rej) begin
            if (w.word_index == WI_INT) begin
                if (ph == PH_FRAC) rej = 1'b1;
                else scan_char(w.ch);
            end else if (w.word_index == WI_SEP) begin
                if (!sep_started) begin
                    sep_started = 1'b1;
                    sep_ok = (w.ch == CH_POINT) && w.word_last;
                end else begin
                    sep_ok = 1'b0;
                end
            end else if (w.word_index == WI_FRAC && !early) begin
                if (frac_started) begin
                    scan_char(w.ch);
                end else if (ph == PH_INT && sep_ok) begin
                    if (is_digit(w.ch) || is_e(w.ch)) begin
                        frac_started = 1'b1;
                        ph = PH_FRAC;
                        scan_char(w.ch);
                    end else begin
                        early = 1'b1;
                    end
                end
            end
        end
        if (w.attempt_last) begin
            ok = !rej;
            if (e_seen && n_exp == 0) ok = 1'b0;
            if (n_int > 1 && coeff_zero) ok = 1'b0;
            if (n_exp > 1 && exp_zero) ok = 1'b0;
            r = '0;
            if (ok) begin
                r.verdict       = frac_started ? VERDICT_THREE : VERDICT_ONE;
                r.int_digits    = clamp8(n_int);
                r.frac_digits   = frac_started ? clamp8(n_frac) : 8'd0;
                r.exp_digits    = clamp8(n_exp);
                r.exp_present   = e_seen;
                r.exp_negative  = e_seen && minus;
                r.point_present = frac_started;
            end
            verdicts_due.insert(verdicts_due.size(), r);
            clear_scan();
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------
    task automatic push_item(input t_in_word w);
        t_pending p;
        p.w = w;
        p.gap = tx_calm ? 0 : int'($urandom_range(0, 11));
        p.drain = next_drain;
        next_drain = 1'b0;
        pend_q.insert(pend_q.size(), p);
    endtask

    // Append one character to the word being built
    task automatic put_char(input logic [7:0] c);
        word_buf.insert(word_buf.size(), c);
    endtask

    // Emit the buffered word; the final one closes the candidate
    task automatic send_word(input logic [1:0] wi, input bit final_word);
        t_in_word w;
        if (final_word && word_buf.size() == 0) put_char(8'(CH_0 + $urandom_range(0, 9)));
        for (int i = 0; i < word_buf.size(); i++) begin
            w.ch = word_buf[i];
            w.word_index = wi;
            w.word_last = (i == word_buf.size() - 1);
            w.attempt_last = final_word && w.word_last;
            push_item(w);
        end
        word_buf.delete();
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    task automatic put_digits(input int n, input bit lead_zero_ok);
        for (int i = 0; i < n; i++) begin
            if (i == 0 && !lead_zero_ok) put_char(8'(CH_0 + $urandom_range(1, 9)));
            else put_char(8'(CH_0 + $urandom_range(0, 9)));
        end
    endtask

    task automatic put_exp();
        int s;
        put_char($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
        s = int'($urandom_range(0, 2));
        if (s == 0) put_char(CH_PLUS);
        else if (s == 1) put_char(CH_MINUS);
        put_digits(($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 3)),
                   $urandom_range(0, 3) == 0);
    endtask

    task automatic maybe_garbage(input int one_in);
        if ($urandom_range(1, one_in) == 1) put_char(8'($urandom_range(0, 255)));
    endtask

    task automatic add_random_candidate();
        int       k;
        int       f;
        t_in_word w;
        k = int'($urandom_range(0, 99));
        if (k < 12) begin
            // raw noise: every field random
            repeat ($urandom_range(1, 4)) begin
                w.ch = 8'($urandom_range(0, 255));
                w.word_index = 2'($urandom_range(0, 3));
                w.word_last = 1'($urandom_range(0, 1));
                w.attempt_last = 1'($urandom_range(0, 1));
                push_item(w);
            end
            return;
        end
        put_digits(($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(1, 4)),
                   $urandom_range(0, 4) == 0);
        if (k < 35) begin
            // integer word alone, optionally with exponent
            if ($urandom_range(0, 1)) put_exp();
            maybe_garbage(10);
            send_word(WI_INT, 1'b1);
        end else if (k < 85) begin
            // integer, separator, fraction
            maybe_garbage(20);
            send_word(WI_INT, 1'b0);
            f = int'($urandom_range(0, 19));
            if (f == 0) put_text("..");
            else if (f == 1) put_char(8'($urandom_range(0, 255)));
            else put_text(".");
            send_word(WI_SEP, 1'b0);
            f = int'($urandom_range(0, 9));
            if (f == 0) begin
                put_char(8'($urandom_range(0, 255)));
                put_digits(int'($urandom_range(0, 2)), 1'b1);
            end else if (f == 1) begin
                put_exp();
            end else begin
                put_digits(int'($urandom_range(1, 4)), 1'b1);
                if ($urandom_range(0, 2) == 0) put_exp();
            end
            maybe_garbage(12);
            if ($urandom_range(0, 11) == 0) begin
                // integer word after the fraction has begun
                send_word(WI_FRAC, 1'b0);
                put_digits(int'($urandom_range(1, 2)), 1'b1);
                send_word(WI_INT, 1'b1);
            end else begin
                send_word(WI_FRAC, 1'b1);
            end
        end else if (k < 92) begin
            // fraction word with no separator: ignored
            send_word(WI_INT, 1'b0);
            put_digits(int'($urandom_range(1, 3)), 1'b1);
            send_word(WI_FRAC, 1'b1);
        end else begin
            // separator with nothing after it
            send_word(WI_INT, 1'b0);
            put_text(".");
            send_word(WI_SEP, 1'b1);
        end
    endtask

    // Counts past saturation in all three fields
    task automatic add_long_candidate();
        put_digits(256, 1'b0);
        send_word(WI_INT, 1'b0);
        put_text(".");
        send_word(WI_SEP, 1'b0);
        put_digits(256, 1'b1);
        put_text("e");
        put_digits(256, 1'b0);
        send_word(WI_FRAC, 1'b1);
    endtask

    // ---------------------------------------------------------------
    // Driver: presents pending words, honours gaps and drain requests
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        logic     nxt_valid;
        t_in_word nxt_word;
        nxt_valid = in_valid;
        nxt_word = in_word;
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                predict_verdict(in_word);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pend_q.size() != 0) begin
                if (pend_q[0].gap != 0) begin
                    pend_q[0].gap = pend_q[0].gap - 1;
                end else if (!pend_q[0].drain || verdicts_due.size() == 0) begin
                    nxt_word = pend_q[0].w;
                    nxt_valid = 1'b1;
                    void'(pend_q.pop_front());
                end
            end
        end
        in_valid <= nxt_valid;
        in_word <= nxt_word;
    end

    // ---------------------------------------------------------------
    // Monitor: random back-pressure and field-by-field comparison
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch("result word with none pending", 1, 0);
                end else begin
                    want = verdicts_due.pop_front();
                    check_field("verdict", o_out_word.verdict, want.verdict);
                    check_field("int_digits", o_out_word.int_digits, want.int_digits);
                    check_field("frac_digits", o_out_word.frac_digits, want.frac_digits);
                    check_field("exp_digits", o_out_word.exp_digits, want.exp_digits);
                    check_field("exp_present", o_out_word.exp_present, want.exp_present);
                    check_field("exp_negative", o_out_word.exp_negative, want.exp_negative);
                    check_field("point_present", o_out_word.point_present,
                                want.point_present);
                end
                if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
                out_wait = rx_calm ? 0 : int'($urandom_range(0, 11));
            end else if (o_out_valid && out_wait != 0) begin
                out_wait--;
            end
            out_stall <= (out_wait != 0);
        end
    end

    // Watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Sequence: build stimulus, reset, drain, verdict
    // ---------------------------------------------------------------
    initial begin
        t_in_word w;
        int       n_cand;
        clear_scan();

        // directed: edge characters and each odd case
        put_text("7");      send_word(WI_INT, 1'b1);
        put_text("00");     send_word(WI_INT, 1'b1);
        put_text("1");      send_word(WI_INT, 1'b0);
        put_text(".");      send_word(WI_SEP, 1'b0);
        put_text("5e-3");   send_word(WI_FRAC, 1'b1);
        put_text("2");      send_word(WI_INT, 1'b0);
        put_text(".");      send_word(WI_SEP, 1'b0);
        put_text("x");      send_word(WI_FRAC, 1'b1);
        put_text("E");      send_word(WI_INT, 1'b1);
        put_text("9E+05");  send_word(WI_INT, 1'b1);
        w = '{ch: 8'h00, word_index: WI_SPARE, word_last: 1'b0, attempt_last: 1'b0};
        push_item(w);
        w = '{ch: 8'hFF, word_index: WI_SPARE, word_last: 1'b1, attempt_last: 1'b1};
        push_item(w);
        put_text("0");      send_word(WI_INT, 1'b0);
        put_text("..");     send_word(WI_SEP, 1'b0);
        put_text("1");      send_word(WI_FRAC, 1'b1);
        put_text("3e");     send_word(WI_INT, 1'b1);

        // random candidates, mostly well formed
        next_drain = 1'b1;
        n_cand = 0;
        while (pend_q.size() < TARGET_WORDS) begin
            if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
            if ($urandom_range(0, 79) == 0) next_drain = 1'b1;
            if (n_cand == 15) add_long_candidate();
            else add_random_candidate();
            n_cand++;
        end

        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || in_valid) @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rlr_pkg.sv
hw/rtl/rlr_scan.sv
hw/rtl/real_literal_recognizer_top.sv
bench/tb.sv
